// File: src/owu_pkg.sv
// ============================================================================
// owu_pkg
// Shared widths, fixed-point constants and helper functions for the
// three-wheel odometry update unit.
// ============================================================================
package owu_pkg;

    // Encoder count width and number of CORDIC rotation steps.
    localparam int COUNT_BITS   = 32;
    localparam int CORDIC_STEPS = 24;

    // Datapath widths.
    localparam int MUL_W  = 34;          // multiplier operand width
    localparam int PROD_W = 2 * MUL_W;   // multiplier product width
    localparam int DIV_W  = 66;          // signed dividend and quotient width
    localparam int DVS_W  = 40;          // signed divisor width
    localparam int ANG_W  = 34;          // CORDIC input angle width
    localparam int WIDE_W = 70;          // working width for sums and saturation

    // Fixed-point constants: angles in Q8.24, unit values in Q2.30.
    localparam logic signed [ANG_W-1:0] Q_TWO_PI  = ANG_W'(105414357);
    localparam logic signed [ANG_W-1:0] Q_PI      = ANG_W'(52707179);
    localparam logic signed [ANG_W-1:0] Q_HALF_PI = ANG_W'(26353589);
    localparam logic signed [ANG_W-1:0] Q_GAIN    = ANG_W'(652032874);
    localparam logic signed [ANG_W-1:0] Q_ONE30   = ANG_W'(1073741824);

    // Configuration register indexes.
    localparam logic [3:0] REG_INCH_PER_COUNT = 4'd0;
    localparam logic [3:0] REG_LEFT_OFFSET    = 4'd1;
    localparam logic [3:0] REG_RIGHT_OFFSET   = 4'd2;
    localparam logic [3:0] REG_BACK_OFFSET    = 4'd3;
    localparam logic [3:0] REG_START_HEADING  = 4'd4;
    localparam logic [3:0] REG_LEFT_ORIGIN    = 4'd5;
    localparam logic [3:0] REG_RIGHT_ORIGIN   = 4'd6;
    localparam logic [3:0] REG_JUMP_LIMIT     = 4'd7;

    // Saturate a wide signed value to the 32-bit signed range.
    function automatic logic signed [31:0] sat32(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] hi;
        logic signed [WIDE_W-1:0] lo;
        hi = WIDE_W'(64'sd2147483647);
        lo = -WIDE_W'(64'sd2147483648);
        if (v > hi) begin
            return 32'sh7FFF_FFFF;
        end else if (v < lo) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    // Divide by 2^30, rounding toward zero.
    function automatic logic signed [WIDE_W-1:0] trunc30(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] bias;
        bias = v[WIDE_W-1] ? WIDE_W'(64'sd1073741823) : '0;
        return (v + bias) >>> 30;
    endfunction

    // Sign-extend the low COUNT_BITS bits of a raw count.
    function automatic logic signed [31:0] sext_count(input logic [31:0] v);
        logic signed [31:0] t;
        t = $signed(v << (32 - COUNT_BITS));
        return t >>> (32 - COUNT_BITS);
    endfunction

    // Arctangent table for the CORDIC, Q8.24 radians.
    function automatic logic signed [ANG_W-1:0] atan_entry(input logic [4:0] i);
        logic signed [ANG_W-1:0] r;
        case (i)
            5'd0:    r = ANG_W'(13176795);
            5'd1:    r = ANG_W'(7778716);
            5'd2:    r = ANG_W'(4110060);
            5'd3:    r = ANG_W'(2086331);
            5'd4:    r = ANG_W'(1047214);
            5'd5:    r = ANG_W'(524117);
            5'd6:    r = ANG_W'(262123);
            5'd7:    r = ANG_W'(131069);
            default: begin
                if (i <= 5'd24) begin
                    r = ANG_W'(1) <<< (5'd24 - i);
                end else begin
                    r = '0;
                end
            end
        endcase
        return r;
    endfunction

endpackage

// File: src/owu_mul.sv
// ============================================================================
// owu_mul
// Shared signed multiplier with a registered product.
// ============================================================================
module owu_mul import owu_pkg::*; (
    input  logic                     i_clk,
    input  logic signed [MUL_W-1:0]  i_a,
    input  logic signed [MUL_W-1:0]  i_b,
    output logic signed [PROD_W-1:0] o_p
);

    logic signed [PROD_W-1:0] r_p;

    // Product register, loaded every cycle.
    always_ff @(posedge i_clk) begin
        r_p <= PROD_W'(i_a) * PROD_W'(i_b);
    end

    assign o_p = r_p;

endmodule

// File: src/owu_div.sv
// ============================================================================
// owu_div
// Shared signed divider, truncating toward zero. Restoring division on the
// magnitudes, one quotient bit per cycle.
// ============================================================================
module owu_div import owu_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [DIV_W-1:0] i_dividend,
    input  logic signed [DVS_W-1:0] i_divisor,
    output logic                    o_done,
    output logic signed [DIV_W-1:0] o_quotient
);

    logic             r_busy;
    logic             r_done;
    logic             r_neg;
    logic [6:0]       r_cnt;
    logic [DIV_W-1:0] r_q;
    logic [DVS_W-1:0] r_dvs;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W:0]   rem_try;
    logic [DVS_W:0]   rem_sub;
    logic             bit_set;

    // One restoring step: bring down the next dividend bit and try the subtract.
    always_comb begin
        rem_try = {r_rem, r_q[DIV_W-1]};
        rem_sub = rem_try - {1'b0, r_dvs};
        bit_set = rem_try >= {1'b0, r_dvs};
    end

    // Control and datapath registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_neg  <= i_dividend[DIV_W-1] ^ i_divisor[DVS_W-1];
                r_q    <= i_dividend[DIV_W-1] ? DIV_W'(-i_dividend) : DIV_W'(i_dividend);
                r_dvs  <= i_divisor[DVS_W-1] ? DVS_W'(-i_divisor) : DVS_W'(i_divisor);
            end else if (r_busy) begin
                r_rem <= bit_set ? rem_sub[DVS_W-1:0] : rem_try[DVS_W-1:0];
                r_q   <= {r_q[DIV_W-2:0], bit_set};
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == 7'(DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_neg ? -$signed(r_q) : $signed(r_q);

endmodule

// File: src/owu_sincos.sv
// ============================================================================
// owu_sincos
// Sine and cosine of a Q8.24 angle in Q2.30. The angle is reduced modulo
// two pi by shifted subtraction, folded into [-pi/2, pi/2], then rotated by
// an iterative CORDIC, one step per cycle.
// ============================================================================
module owu_sincos import owu_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [ANG_W-1:0] i_angle,
    output logic                    o_done,
    output logic signed [31:0]      o_cos,
    output logic signed [31:0]      o_sin
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_REDUCE = 2'd1;
    localparam logic [1:0] ST_FOLD   = 2'd2;
    localparam logic [1:0] ST_ROTATE = 2'd3;

    logic [1:0]              r_st;
    logic                    r_done;
    logic                    r_neg;
    logic                    r_flip;
    logic [2:0]              r_k;
    logic [4:0]              r_i;
    logic [ANG_W-1:0]        r_m;
    logic signed [ANG_W-1:0] r_x;
    logic signed [ANG_W-1:0] r_y;
    logic signed [ANG_W-1:0] r_z;
    logic signed [31:0]      r_cos;
    logic signed [31:0]      r_sin;

    logic [ANG_W-1:0]        red_step;
    logic signed [ANG_W-1:0] fold_a;
    logic signed [ANG_W-1:0] fold_b;
    logic signed [ANG_W-1:0] fold_z;
    logic                    fold_flip;
    logic signed [ANG_W-1:0] xs;
    logic signed [ANG_W-1:0] ys;
    logic signed [ANG_W-1:0] x_nxt;
    logic signed [ANG_W-1:0] y_nxt;
    logic signed [ANG_W-1:0] x_fin;
    logic signed [ANG_W-1:0] y_fin;
    logic signed [31:0]      c_clamp;
    logic signed [31:0]      s_clamp;

    // Angle reduction and folding.
    always_comb begin
        red_step = ANG_W'(Q_TWO_PI) << r_k;
        fold_a   = (r_neg && (r_m != '0)) ? Q_TWO_PI - $signed(r_m) : $signed(r_m);
        fold_b   = (fold_a >= Q_PI) ? fold_a - Q_TWO_PI : fold_a;
        if (fold_b > Q_HALF_PI) begin
            fold_z    = fold_b - Q_PI;
            fold_flip = 1'b1;
        end else if (fold_b < -Q_HALF_PI) begin
            fold_z    = fold_b + Q_PI;
            fold_flip = 1'b1;
        end else begin
            fold_z    = fold_b;
            fold_flip = 1'b0;
        end
    end

    // One CORDIC rotation step and the final sign flip and clamp.
    always_comb begin
        xs = r_x >>> r_i;
        ys = r_y >>> r_i;
        if (r_z >= 0) begin
            x_nxt = r_x - ys;
            y_nxt = r_y + xs;
        end else begin
            x_nxt = r_x + ys;
            y_nxt = r_y - xs;
        end
        x_fin = r_flip ? -x_nxt : x_nxt;
        y_fin = r_flip ? -y_nxt : y_nxt;
        if (x_fin > Q_ONE30) begin
            c_clamp = 32'(Q_ONE30);
        end else if (x_fin < -Q_ONE30) begin
            c_clamp = 32'(-Q_ONE30);
        end else begin
            c_clamp = x_fin[31:0];
        end
        if (y_fin > Q_ONE30) begin
            s_clamp = 32'(Q_ONE30);
        end else if (y_fin < -Q_ONE30) begin
            s_clamp = 32'(-Q_ONE30);
        end else begin
            s_clamp = y_fin[31:0];
        end
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= ST_IDLE;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_st)
                ST_IDLE: begin
                    if (i_start) begin
                        r_neg <= i_angle[ANG_W-1];
                        r_m   <= i_angle[ANG_W-1] ? ANG_W'(-i_angle) : ANG_W'(i_angle);
                        r_k   <= 3'd6;
                        r_st  <= ST_REDUCE;
                    end
                end
                ST_REDUCE: begin
                    if (r_m >= red_step) begin
                        r_m <= r_m - red_step;
                    end
                    if (r_k == 3'd0) begin
                        r_st <= ST_FOLD;
                    end else begin
                        r_k <= r_k - 3'd1;
                    end
                end
                ST_FOLD: begin
                    r_z    <= fold_z;
                    r_flip <= fold_flip;
                    r_x    <= Q_GAIN;
                    r_y    <= '0;
                    r_i    <= '0;
                    r_st   <= ST_ROTATE;
                end
                ST_ROTATE: begin
                    r_x <= x_nxt;
                    r_y <= y_nxt;
                    r_z <= (r_z >= 0) ? r_z - atan_entry(r_i) : r_z + atan_entry(r_i);
                    r_i <= r_i + 5'd1;
                    if (r_i == 5'(CORDIC_STEPS - 1)) begin
                        r_cos  <= c_clamp;
                        r_sin  <= s_clamp;
                        r_done <= 1'b1;
                        r_st   <= ST_IDLE;
                    end
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_cos  = r_cos;
    assign o_sin  = r_sin;

endmodule

// File: src/three_wheel_odometry_update_unit.sv
// ============================================================================
// three_wheel_odometry_update_unit
// Arc odometry from three tracking wheels: one pose update per transaction.
// ============================================================================
// Usage:
// - Input channel (i_in_valid / o_in_stall) carries the three raw encoder
//   counts. A transaction completes when valid is high and stall is low.
// - Output channel (o_out_valid / i_out_stall) carries the saturated pose,
//   the heading and the two jump flags, one result per input transaction.
// - The configuration channel (i_cfg_valid / o_cfg_ready) writes one of eight
//   registers by index; it is always ready and should only be used while the
//   unit is idle. Indexes above seven are ignored.
// - A tick that turns runs the heading division, two chord divisions, two
//   CORDIC passes and eleven multiplies; a straight tick skips the chord
//   arithmetic and the first CORDIC pass. The heading division is skipped
//   when both wheel offsets are zero. The shared divider sets most of the
//   time. A new tick can be accepted in the cycle after a commit.
// - One tick is processed at a time; stall stays high while it is in work.
//   A finished result waits in the output register, so the next tick may be
//   accepted while the receiver stalls; the unit then holds before loading
//   the following result until the register is free.
// - Reset (synchronous, active low) restores default registers and clears
//   the pose, the heading and the wheel history.
// ============================================================================
module three_wheel_odometry_update_unit import owu_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [31:0] i_left_count,
    input  logic signed [31:0] i_right_count,
    input  logic signed [31:0] i_back_count,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_pose_x,
    output logic signed [31:0] o_pose_y,
    output logic signed [31:0] o_pose_heading,
    output logic               o_x_rejected,
    output logic               o_y_rejected,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [3:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_ML   = 5'd1;
    localparam logic [4:0] S_MR   = 5'd2;
    localparam logic [4:0] S_MB   = 5'd3;
    localparam logic [4:0] S_HD   = 5'd4;
    localparam logic [4:0] S_HW   = 5'd5;
    localparam logic [4:0] S_DA   = 5'd6;
    localparam logic [4:0] S_SW   = 5'd7;
    localparam logic [4:0] S_A1   = 5'd8;
    localparam logic [4:0] S_A2   = 5'd9;
    localparam logic [4:0] S_A3   = 5'd10;
    localparam logic [4:0] S_A4   = 5'd11;
    localparam logic [4:0] S_A5   = 5'd12;
    localparam logic [4:0] S_A6   = 5'd13;
    localparam logic [4:0] S_A7   = 5'd14;
    localparam logic [4:0] S_A8   = 5'd15;
    localparam logic [4:0] S_ROT  = 5'd16;
    localparam logic [4:0] S_RW   = 5'd17;
    localparam logic [4:0] S_R1   = 5'd18;
    localparam logic [4:0] S_R2   = 5'd19;
    localparam logic [4:0] S_R3   = 5'd20;
    localparam logic [4:0] S_R4   = 5'd21;
    localparam logic [4:0] S_R5   = 5'd22;
    localparam logic [4:0] S_OUT  = 5'd23;

    // Configuration registers.
    logic [31:0]        r_ipc;
    logic [30:0]        r_lo_off;
    logic [30:0]        r_ro_off;
    logic [30:0]        r_bo_off;
    logic signed [31:0] r_start;
    logic signed [31:0] r_l_origin;
    logic signed [31:0] r_r_origin;
    logic [30:0]        r_jl;

    // Odometry state.
    logic signed [31:0] r_prev_r;
    logic signed [31:0] r_prev_b;
    logic signed [31:0] r_prev_h;
    logic signed [31:0] r_acc_x;
    logic signed [31:0] r_acc_y;

    // Sequencer and working registers.
    logic [4:0]          r_state;
    logic signed [31:0]  r_cnt_l;
    logic signed [31:0]  r_cnt_r;
    logic signed [31:0]  r_cnt_b;
    logic signed [31:0]  r_pl;
    logic signed [31:0]  r_pr;
    logic signed [31:0]  r_pb;
    logic signed [31:0]  r_heading;
    logic signed [32:0]  r_da;
    logic signed [31:0]  r_half;
    logic signed [32:0]  r_two_s;
    logic signed [35:0]  r_term;
    logic signed [31:0]  r_dx;
    logic signed [31:0]  r_dy;
    logic signed [PROD_W-1:0] r_part;
    logic signed [35:0]  r_gx;
    logic signed [35:0]  r_gy;

    // Output register.
    logic               r_out_valid;
    logic signed [31:0] r_out_x;
    logic signed [31:0] r_out_y;
    logic signed [31:0] r_out_h;
    logic               r_out_xr;
    logic               r_out_yr;

    // Shared unit connections.
    logic signed [MUL_W-1:0]  mul_a;
    logic signed [MUL_W-1:0]  mul_b;
    logic signed [PROD_W-1:0] prod;
    logic                     div_start;
    logic signed [DIV_W-1:0]  div_dvd;
    logic signed [DVS_W-1:0]  div_dvs;
    logic                     div_done;
    logic signed [DIV_W-1:0]  div_q;
    logic                     cs_start;
    logic signed [ANG_W-1:0]  cs_angle;
    logic                     cs_done;
    logic signed [31:0]       cs_cos;
    logic signed [31:0]       cs_sin;

    // Derived values.
    logic signed [32:0]       d_r;
    logic signed [32:0]       d_b;
    logic signed [33:0]       num;
    logic signed [DVS_W-1:0]  den;
    logic signed [DVS_W-1:0]  dv;
    logic signed [32:0]       da_c;
    logic signed [31:0]       inches;
    logic signed [WIDE_W-1:0] trunc_p;
    logic                     x_rej;
    logic                     y_rej;
    logic signed [35:0]       gx_use;
    logic signed [35:0]       gy_use;
    logic                     out_free;

    owu_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (prod)
    );

    owu_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    owu_sincos u_sincos (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cs_start),
        .i_angle (cs_angle),
        .o_done  (cs_done),
        .o_cos   (cs_cos),
        .o_sin   (cs_sin)
    );

    // Wheel and heading differences, divider operands and rounding helpers.
    always_comb begin
        d_r     = 33'(r_pr) - 33'(r_prev_r);
        d_b     = 33'(r_pb) - 33'(r_prev_b);
        num     = 34'(r_pl) - 34'(r_l_origin) - 34'(r_pr) + 34'(r_r_origin);
        den     = $signed(DVS_W'(r_lo_off) + DVS_W'(r_ro_off));
        dv      = DVS_W'(r_da) <<< 6;
        da_c    = 33'(r_heading) - 33'(r_prev_h);
        inches  = sat32((WIDE_W'(prod) + WIDE_W'(64'sd128)) >>> 8);
        trunc_p = trunc30(WIDE_W'(prod));
        x_rej   = (r_gx > $signed(36'(r_jl))) || (-r_gx > $signed(36'(r_jl)));
        y_rej   = (r_gy > $signed(36'(r_jl))) || (-r_gy > $signed(36'(r_jl)));
        gx_use  = x_rej ? '0 : r_gx;
        gy_use  = y_rej ? '0 : r_gy;
        out_free = !r_out_valid || !i_out_stall;
    end

    // Multiplier operand selection; the product is read one state later.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_ML: begin
                mul_a = MUL_W'(r_cnt_l);
                mul_b = $signed(MUL_W'(r_ipc));
            end
            S_MR: begin
                mul_a = MUL_W'(r_cnt_r);
                mul_b = $signed(MUL_W'(r_ipc));
            end
            S_MB: begin
                mul_a = MUL_W'(r_cnt_b);
                mul_b = $signed(MUL_W'(r_ipc));
            end
            S_A1: begin
                mul_a = MUL_W'(d_b);
                mul_b = MUL_W'(r_two_s);
            end
            S_A2: begin
                mul_a = $signed(MUL_W'(r_bo_off));
                mul_b = MUL_W'(r_two_s);
            end
            S_A5: begin
                mul_a = MUL_W'(d_r);
                mul_b = MUL_W'(r_two_s);
            end
            S_A6: begin
                mul_a = $signed(MUL_W'(r_ro_off));
                mul_b = MUL_W'(r_two_s);
            end
            S_R1: begin
                mul_a = MUL_W'(r_dx);
                mul_b = MUL_W'(cs_cos);
            end
            S_R2: begin
                mul_a = MUL_W'(r_dy);
                mul_b = MUL_W'(cs_sin);
            end
            S_R3: begin
                mul_a = MUL_W'(r_dy);
                mul_b = MUL_W'(cs_cos);
            end
            S_R4: begin
                mul_a = MUL_W'(r_dx);
                mul_b = MUL_W'(cs_sin);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Divider and CORDIC launches.
    always_comb begin
        div_start = ((r_state == S_HD) && (den != '0)) || (r_state == S_A2) ||
                    (r_state == S_A6);
        div_dvd   = (r_state == S_HD) ? (DIV_W'(num) <<< 24) : $signed(prod[DIV_W-1:0]);
        div_dvs   = (r_state == S_HD) ? den : dv;
        cs_start  = ((r_state == S_DA) && (da_c != '0)) || (r_state == S_ROT);
        cs_angle  = (r_state == S_DA) ? ANG_W'(32'(da_c >>> 1))
                                      : ANG_W'(r_prev_h) + ANG_W'(r_half);
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ipc      <= 32'd402614;
            r_lo_off   <= 31'd327680;
            r_ro_off   <= 31'd327680;
            r_bo_off   <= 31'd327680;
            r_start    <= '0;
            r_l_origin <= '0;
            r_r_origin <= '0;
            r_jl       <= 31'd655360;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_INCH_PER_COUNT: r_ipc      <= i_cfg_data;
                REG_LEFT_OFFSET:    r_lo_off   <= i_cfg_data[30:0];
                REG_RIGHT_OFFSET:   r_ro_off   <= i_cfg_data[30:0];
                REG_BACK_OFFSET:    r_bo_off   <= i_cfg_data[30:0];
                REG_START_HEADING:  r_start    <= $signed(i_cfg_data);
                REG_LEFT_ORIGIN:    r_l_origin <= $signed(i_cfg_data);
                REG_RIGHT_ORIGIN:   r_r_origin <= $signed(i_cfg_data);
                REG_JUMP_LIMIT:     r_jl       <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // Update sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_prev_r    <= '0;
            r_prev_b    <= '0;
            r_prev_h    <= '0;
            r_acc_x     <= '0;
            r_acc_y     <= '0;
        end else begin
            if (r_out_valid && !i_out_stall && !((r_state == S_OUT) && out_free)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_cnt_l <= sext_count(i_left_count);
                        r_cnt_r <= sext_count(i_right_count);
                        r_cnt_b <= sext_count(i_back_count);
                        r_state <= S_ML;
                    end
                end
                S_ML: r_state <= S_MR;
                S_MR: begin
                    r_pl    <= inches;
                    r_state <= S_MB;
                end
                S_MB: begin
                    r_pr    <= inches;
                    r_state <= S_HD;
                end
                S_HD: begin
                    r_pb <= inches;
                    if (den == '0) begin
                        r_heading <= r_start;
                        r_state   <= S_DA;
                    end else begin
                        r_state <= S_HW;
                    end
                end
                S_HW: begin
                    if (div_done) begin
                        r_heading <= sat32(WIDE_W'(r_start) + WIDE_W'(div_q));
                        r_state   <= S_DA;
                    end
                end
                S_DA: begin
                    r_da   <= da_c;
                    r_half <= 32'(da_c >>> 1);
                    if (da_c == '0) begin
                        // Straight tick: the wheel travel is the local displacement.
                        r_dx    <= sat32(WIDE_W'(d_b));
                        r_dy    <= sat32(WIDE_W'(d_r));
                        r_state <= S_ROT;
                    end else begin
                        r_state <= S_SW;
                    end
                end
                S_SW: begin
                    if (cs_done) begin
                        r_two_s <= 33'(cs_sin) <<< 1;
                        r_state <= S_A1;
                    end
                end
                S_A1: r_state <= S_A2;
                S_A2: r_state <= S_A3;
                S_A3: begin
                    r_term  <= trunc_p[35:0];
                    r_state <= S_A4;
                end
                S_A4: begin
                    if (div_done) begin
                        r_dx    <= sat32(WIDE_W'(div_q) + WIDE_W'(r_term));
                        r_state <= S_A5;
                    end
                end
                S_A5: r_state <= S_A6;
                S_A6: r_state <= S_A7;
                S_A7: begin
                    r_term  <= trunc_p[35:0];
                    r_state <= S_A8;
                end
                S_A8: begin
                    if (div_done) begin
                        r_dy    <= sat32(WIDE_W'(div_q) + WIDE_W'(r_term));
                        r_state <= S_ROT;
                    end
                end
                S_ROT: r_state <= S_RW;
                S_RW: begin
                    if (cs_done) begin
                        r_state <= S_R1;
                    end
                end
                S_R1: r_state <= S_R2;
                S_R2: begin
                    r_part  <= prod;
                    r_state <= S_R3;
                end
                S_R3: begin
                    r_gx    <= 36'(trunc30(WIDE_W'(r_part) + WIDE_W'(prod)));
                    r_state <= S_R4;
                end
                S_R4: begin
                    r_part  <= prod;
                    r_state <= S_R5;
                end
                S_R5: begin
                    r_gy    <= 36'(trunc30(WIDE_W'(r_part) - WIDE_W'(prod)));
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    // Commit the tick once the output register can take it.
                    if (out_free) begin
                        r_acc_x     <= sat32(WIDE_W'(r_acc_x) + WIDE_W'(gx_use));
                        r_acc_y     <= sat32(WIDE_W'(r_acc_y) + WIDE_W'(gy_use));
                        r_out_x     <= sat32(WIDE_W'(r_acc_x) + WIDE_W'(gx_use));
                        r_out_y     <= sat32(WIDE_W'(r_acc_y) + WIDE_W'(gy_use));
                        r_out_h     <= r_heading;
                        r_out_xr    <= x_rej;
                        r_out_yr    <= y_rej;
                        r_out_valid <= 1'b1;
                        r_prev_r    <= r_pr;
                        r_prev_b    <= r_pb;
                        r_prev_h    <= r_heading;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_pose_x       = r_out_x;
    assign o_pose_y       = r_out_y;
    assign o_pose_heading = r_out_h;
    assign o_x_rejected   = r_out_xr;
    assign o_y_rejected   = r_out_yr;
    assign o_cfg_ready    = 1'b1;

endmodule

// File: tb/sv/tb_three_wheel_odometry_update_unit.sv
// ============================================================================
// tb_three_wheel_odometry_update_unit
// Self-checking testbench for the three-wheel arc odometry update unit.
// A short table of directed ticks runs first. Several register settings then
// follow, each with random encoder walks, straight ticks and raw noise. A
// bit-exact fixed-point pose predictor checks every result in order.
// ============================================================================
module tb_three_wheel_odometry_update_unit import owu_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [127:0] t_wide;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] hd;
        logic               xr;
        logic               yr;
    } t_pose;

    typedef struct packed {
        logic signed [31:0] l;
        logic signed [31:0] r;
        logic signed [31:0] b;
        logic               typed;
        t_pose              want;
    } t_tick_row;

    localparam logic [3:0] REG_NONE = 4'd12;   // index past the register file
    localparam int IDLE_LIMIT = 20000;
    localparam int DRAIN_WAIT = 400;
    localparam int LONG_HOLD  = 2000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic signed [31:0] i_left_count = '0;
    logic signed [31:0] i_right_count = '0;
    logic signed [31:0] i_back_count = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b1;
    logic signed [31:0] o_pose_x;
    logic signed [31:0] o_pose_y;
    logic signed [31:0] o_pose_heading;
    logic               o_x_rejected;
    logic               o_y_rejected;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [3:0]         i_cfg_index = '0;
    logic [31:0]        i_cfg_data = '0;

    // Predictor registers and state.
    t_wide inch_scale, left_off, right_off, back_off, heading0, left_org, right_org, jump_max;
    t_wide last_left, last_right, last_back, last_heading, pos_x, pos_y;

    t_pose pending_poses[$];
    int    err_count = 0;
    int    idle_cycles = 0;
    bit    long_hold_req = 1'b0;

    three_wheel_odometry_update_unit u_top (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_wide clip32(t_wide v);
        if (v > 128'sd2147483647) return 128'sd2147483647;
        if (v < -128'sd2147483648) return -128'sd2147483648;
        return v;
    endfunction

    function automatic t_wide clip_unit(t_wide v);
        if (v > 128'sd1073741824) return 128'sd1073741824;
        if (v < -128'sd1073741824) return -128'sd1073741824;
        return v;
    endfunction

    function automatic t_wide arctan_step(int i);
        case (i)
            0: return 13176795;
            1: return 7778716;
            2: return 4110060;
            3: return 2086331;
            4: return 1047214;
            5: return 524117;
            6: return 262123;
            7: return 131069;
            default: return (i <= 24) ? (t_wide'(1) <<< (24 - i)) : t_wide'(0);
        endcase
    endfunction

    // Cosine and sine (Q2.30) of a Q8.24 angle by rotation CORDIC.
    task automatic cordic_sincos(input t_wide ang, output t_wide c, output t_wide s);
        t_wide r, x, y, z, xs, ys;
        bit flip;
        r = ang % t_wide'(Q_TWO_PI);
        x = t_wide'(Q_GAIN);
        y = 0;
        flip = 1'b0;
        if (r < 0) r = r + t_wide'(Q_TWO_PI);
        if (r >= t_wide'(Q_PI)) r = r - t_wide'(Q_TWO_PI);
        if (r > t_wide'(Q_HALF_PI)) begin
            r = r - t_wide'(Q_PI);
            flip = 1'b1;
        end else if (r < -t_wide'(Q_HALF_PI)) begin
            r = r + t_wide'(Q_PI);
            flip = 1'b1;
        end
        z = r;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x = x - ys;
                y = y + xs;
                z = z - arctan_step(i);
            end else begin
                x = x + ys;
                y = y - xs;
                z = z + arctan_step(i);
            end
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        c = clip_unit(x);
        s = clip_unit(y);
    endtask

    function automatic t_wide count_to_inches(logic [31:0] raw);
        t_wide cnt;
        cnt = t_wide'($signed(raw << (32 - COUNT_BITS)) >>> (32 - COUNT_BITS));
        return clip32((cnt * inch_scale + 128) >>> 8);
    endfunction

    task automatic reset_pose_model();
        inch_scale = 402614;
        left_off = 327680;
        right_off = 327680;
        back_off = 327680;
        heading0 = 0;
        left_org = 0;
        right_org = 0;
        jump_max = 655360;
        last_left = 0;
        last_right = 0;
        last_back = 0;
        last_heading = 0;
        pos_x = 0;
        pos_y = 0;
    endtask

    task automatic apply_register(logic [3:0] idx, logic [31:0] d);
        case (idx)
            REG_INCH_PER_COUNT: inch_scale = t_wide'({1'b0, d});
            REG_LEFT_OFFSET:    left_off = t_wide'({1'b0, d[30:0]});
            REG_RIGHT_OFFSET:   right_off = t_wide'({1'b0, d[30:0]});
            REG_BACK_OFFSET:    back_off = t_wide'({1'b0, d[30:0]});
            REG_START_HEADING:  heading0 = t_wide'($signed(d));
            REG_LEFT_ORIGIN:    left_org = t_wide'($signed(d));
            REG_RIGHT_ORIGIN:   right_org = t_wide'($signed(d));
            REG_JUMP_LIMIT:     jump_max = t_wide'({1'b0, d[30:0]});
            default: ;
        endcase
    endtask

    // Advance the pose for one tick and return the result it produces.
    task automatic update_pose(input logic [31:0] lc, rc, bc, output t_pose p);
        t_wide pl, pr, pb, d_r, d_b, num, den, q, hd, da, half, dx, dy, c, s, two_s, gx, gy;
        pl = count_to_inches(lc);
        pr = count_to_inches(rc);
        pb = count_to_inches(bc);
        d_r = pr - last_right;
        d_b = pb - last_back;
        num = (pl - left_org) - (pr - right_org);
        den = left_off + right_off;
        q = (den != 0) ? (num <<< 24) / den : t_wide'(0);
        hd = clip32(heading0 + q);
        da = hd - last_heading;
        half = da >>> 1;
        if (da == 0) begin
            dx = d_b;
            dy = d_r;
        end else begin
            cordic_sincos(half, c, s);
            two_s = 2 * s;
            dx = (d_b * two_s) / (da * 64) + (back_off * two_s) / t_wide'(Q_ONE30);
            dy = (d_r * two_s) / (da * 64) + (right_off * two_s) / t_wide'(Q_ONE30);
        end
        dx = clip32(dx);
        dy = clip32(dy);
        cordic_sincos(last_heading + half, c, s);
        gx = (dx * c + dy * s) / t_wide'(Q_ONE30);
        gy = (dy * c - dx * s) / t_wide'(Q_ONE30);
        p.xr = (gx > jump_max) || (-gx > jump_max);
        p.yr = (gy > jump_max) || (-gy > jump_max);
        if (p.xr) gx = 0;
        if (p.yr) gy = 0;
        pos_x = clip32(pos_x + gx);
        pos_y = clip32(pos_y + gy);
        last_left = pl;
        last_right = pr;
        last_back = pb;
        last_heading = hd;
        p.x = pos_x[31:0];
        p.y = pos_y[31:0];
        p.hd = hd[31:0];
    endtask

    // Present one tick after a random gap; predict it once accepted.
    task automatic send_tick(logic [31:0] lc, rc, bc, bit typed, t_pose want);
        t_pose p;
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
        repeat (gap) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_left_count <= lc;
        i_right_count <= rc;
        i_back_count <= bc;
        do @(posedge i_clk); while (o_in_stall);
        update_pose(lc, rc, bc, p);
        pending_poses.push_back(typed ? want : p);
    endtask

    task automatic write_register(logic [3:0] idx, logic [31:0] d);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        apply_register(idx, d);
    endtask

    // Let every pending result arrive, then let the unit go fully quiet.
    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_poses.size() > 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_offset();
        case ($urandom_range(0, 4))
            0: return 32'h0;
            1: return 32'h7FFF_FFFF | ($urandom_range(0, 1) << 31);
            default: return $urandom_range(65536, 1 << 22) | ($urandom_range(0, 1) << 31);
        endcase
    endfunction

    // Write every register with a new setting; some phases use the extremes.
    task automatic program_phase(int ph);
        logic [31:0] ipc, lo, ro;
        case (ph)
            1: ipc = 32'h0;
            2: ipc = 32'hFFFF_FFFF;
            3: ipc = 402614;
            default: ipc = $urandom_range(100000, 4000000);
        endcase
        lo = pick_offset();
        ro = pick_offset();
        if (ph == 3) begin
            lo = 32'h8000_0000;
            ro = 32'h0;
        end
        write_register(REG_INCH_PER_COUNT, ipc);
        write_register(REG_LEFT_OFFSET, lo);
        write_register(REG_RIGHT_OFFSET, ro);
        write_register(REG_BACK_OFFSET, pick_offset());
        write_register(REG_START_HEADING, (ph == 2) ? 32'h8000_0000 : $urandom());
        write_register(REG_LEFT_ORIGIN, (ph == 2) ? 32'h7FFF_FFFF : $urandom());
        write_register(REG_RIGHT_ORIGIN, (ph == 2) ? 32'h8000_0000 : $urandom());
        case (ph)
            1: write_register(REG_JUMP_LIMIT, 32'h0);
            2: write_register(REG_JUMP_LIMIT, 32'hFFFF_FFFF);
            default: write_register(REG_JUMP_LIMIT, $urandom_range(1 << 16, 1 << 24));
        endcase
        write_register(REG_NONE, $urandom());
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Result checker: compare each result with the oldest prediction.
    always @(posedge i_clk) begin
        t_pose w;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_poses.size() == 0) begin
                $error("unexpected result transaction");
                err_count++;
            end else begin
                w = pending_poses.pop_front();
                if (o_pose_x !== w.x) begin
                    $error("pose_x expected %0d actual %0d", w.x, o_pose_x);
                    err_count++;
                end
                if (o_pose_y !== w.y) begin
                    $error("pose_y expected %0d actual %0d", w.y, o_pose_y);
                    err_count++;
                end
                if (o_pose_heading !== w.hd) begin
                    $error("pose_heading expected %0d actual %0d", w.hd, o_pose_heading);
                    err_count++;
                end
                if (o_x_rejected !== w.xr) begin
                    $error("x_rejected expected %0b actual %0b", w.xr, o_x_rejected);
                    err_count++;
                end
                if (o_y_rejected !== w.yr) begin
                    $error("y_rejected expected %0b actual %0b", w.yr, o_y_rejected);
                    err_count++;
                end
            end
        end
    end

    // Watchdog on cycles in which no transaction of any kind completes.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Result receiver: random stalls per transaction, one long hold-off on request.
    initial begin
        int n;
        @(posedge i_rst_n);
        forever begin
            n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
            repeat (n) begin
                @(negedge i_clk);
                i_out_stall <= 1'b1;
            end
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                @(negedge i_clk);
                i_out_stall <= 1'b1;
                repeat (LONG_HOLD) @(negedge i_clk);
            end
            @(negedge i_clk);
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!(o_out_valid && !i_out_stall));
        end
    end

    // Stimulus: directed table, then random phases under varied settings.
    initial begin
        t_tick_row rows[$];
        logic [31:0] wl, wr, wb, step;
        int kind;
        reset_pose_model();
        rows = '{
            '{32'sd0, 32'sd0, 32'sd0, 1'b1, '{32'sd0, 32'sd0, 32'sd0, 1'b0, 1'b0}},
            '{32'sd1000, 32'sd1000, 32'sd0, 1'b0, '0},
            '{32'sd1000, 32'sd1000, 32'sd500, 1'b0, '0},
            '{32'sd3000, 32'sd1000, 32'sd500, 1'b0, '0},
            '{32'sd1000, 32'sd3000, -32'sd500, 1'b0, '0},
            '{32'sd1200, 32'sd1250, -32'sd480, 1'b0, '0},
            '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, '0},
            '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0, '0},
            '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 1'b0, '0},
            '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0},
            '{32'hFFFF_FFFF, 32'h0000_0001, 32'h5555_5555, 1'b0, '0},
            '{32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0, '0},
            '{32'sd0, 32'sd0, 32'sd0, 1'b0, '0},
            '{32'sd0, 32'sd0, 32'sd0, 1'b0, '0}
        };
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[i]) send_tick(rows[i].l, rows[i].r, rows[i].b, rows[i].typed, rows[i].want);
        drain_results();

        for (int ph = 0; ph < 5; ph++) begin
            if (ph > 0) program_phase(ph);
            if (ph == 2) long_hold_req = 1'b1;
            wl = $urandom_range(0, 4000);
            wr = wl;
            wb = 0;
            for (int k = 0; k < 100; k++) begin
                kind = $urandom_range(0, 9);
                step = $urandom_range(0, (1 << $urandom_range(0, 14)));
                if (kind == 0) begin
                    // Raw noise across the full count range.
                    wl = $urandom();
                    wr = $urandom();
                    wb = $urandom();
                end else if (kind == 1) begin
                    // Straight tick: both side wheels travel the same amount.
                    wl = wl + step;
                    wr = wr + step;
                end else begin
                    wl = wl + ($urandom_range(0, 1) ? step : -step);
                    wr = wr + ($urandom_range(0, 1) ? step : -step) / 2;
                    wb = wb + $signed($urandom_range(0, 600)) - 300;
                end
                send_tick(wl, wr, wb, 1'b0, '0);
            end
            drain_results();
        end

        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// File: filelist.f
src/owu_pkg.sv
src/owu_mul.sv
src/owu_div.sv
src/owu_sincos.sv
src/three_wheel_odometry_update_unit.sv
tb/sv/tb_three_wheel_odometry_update_unit.sv
